[rtl/gpp_pkg.sv]
// shared types, constants and command codes of the genotype projection block
package gpp_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_PCS     = 32;
    localparam int SMP_W       = $clog2(MAX_SAMPLES);
    localparam int PC_W        = $clog2(MAX_PCS);
    localparam int ACC_ADDR_W  = SMP_W + PC_W;
    localparam int ACC_W       = 48;
    localparam int WGT_W       = 32;
    localparam int AF_W        = 16;
    localparam int INV_W       = 32;
    localparam int NPC_W       = 6;

    localparam logic [1:0] CMD_SITE   = 2'd0;
    localparam logic [1:0] CMD_WEIGHT = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_DOSE = 2'd2;
    localparam logic [1:0] ST_MONO = 2'd3;

    localparam logic [0:0] REG_HOMREF = 1'b0;
    localparam logic [0:0] REG_NPC    = 1'b1;

    // site start handed to the reciprocal sd unit
    typedef struct packed {
        logic            start;
        logic [AF_W-1:0] af;
    } t_sd_req;

    typedef struct packed {
        logic             done;
        logic [INV_W-1:0] inv_sd;
    } t_sd_rsp;

endpackage

[rtl/gpp_inv_sd.sv]
// reciprocal standard deviation unit: bit-serial square root then restoring divide
module gpp_inv_sd (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gpp_pkg::t_sd_req i_req,
    output gpp_pkg::t_sd_rsp o_rsp
);
    import gpp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SQRT = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [63:0]   r_x, n_x;      // sqrt remainder / divide remainder
    logic [63:0]   r_r, n_r;      // sqrt root / divisor
    logic [63:0]   r_bit, n_bit;
    logic [56:0]   r_q, n_q;      // dividend shift register (bits of 2^56)
    logic [5:0]    r_cnt, n_cnt;
    logic [INV_W-1:0] r_inv, n_inv;
    logic [32:0]   v;
    logic [64:0]   rem_sh;

    // v = 2*af*(65536-af), at most 2^31
    assign v = {16'd0, i_req.af, 1'b0} * ({16'd0, 17'h10000} - {17'd0, i_req.af});

    always_comb begin
        n_state = r_state;
        n_x = r_x;
        n_r = r_r;
        n_bit = r_bit;
        n_q = r_q;
        n_cnt = r_cnt;
        n_inv = r_inv;
        rem_sh = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    if (i_req.af == '0) begin
                        n_inv = '0;
                        n_state = S_DONE;
                    end else begin
                        n_x = {v[31:0], 32'd0};
                        if (v[32]) n_x = 64'h8000_0000_0000_0000;
                        n_r = '0;
                        n_bit = 64'h4000_0000_0000_0000;
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                if (r_x >= r_r + r_bit) begin
                    n_x = r_x - (r_r + r_bit);
                    n_r = (r_r >> 1) + r_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_x = '0;
                    n_q = {1'b1, 56'd0};
                    n_cnt = 6'd56;
                    n_state = S_DIV;
                    if (r_x >= r_r + r_bit) n_r = (r_r >> 1) + r_bit;
                    else n_r = r_r >> 1;
                end
            end
            S_DIV: begin
                // restoring division of 2^56 by the root, one bit a cycle
                rem_sh = {r_x, r_q[56]};
                n_q = {r_q[55:0], 1'b0};
                if (rem_sh >= {1'b0, r_r}) begin
                    n_x = 64'(rem_sh - {1'b0, r_r});
                    n_inv = {r_inv[INV_W-2:0], 1'b1};
                end else begin
                    n_x = rem_sh[63:0];
                    n_inv = {r_inv[INV_W-2:0], 1'b0};
                end
                if (r_cnt == '0) n_state = S_DONE;
                else n_cnt = r_cnt - 6'd1;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x <= n_x;
        r_r <= n_r;
        r_bit <= n_bit;
        r_q <= n_q;
        r_cnt <= n_cnt;
        r_inv <= n_inv;
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.inv_sd = r_inv;

endmodule

[rtl/genotype_pca_projection_top.sv]
// top level of the genotype projection block: command decode, score and accumulator sweep
//
// usage
//   s_axis carries one command word a time; tdata packs cmd, allele_freq, weights_valid,
//   component, weight, sample, allele_a, allele_b, genotype_present from bit 0 up
//   m_axis returns one result word per command: value (48 bits) then status (2 bits)
//   the config channel writes register 0 (missing_as_ref) or 1 (num_components)
// operation
//   a site word runs a 32-step bit-serial square root and a 57-step divide that produce
//   the reciprocal standard deviation
//   a sample word takes a score multiply, then a read-modify-write per component of the
//   accumulator memory (read, multiply-add, write)
// reset
//   after reset a clearing pass zeroes the 32768-entry accumulator memory, one entry a
//   cycle, during which no word is taken; config writes are taken always
// stall
//   the result sits in an output register; a new word is taken only once it is gone,
//   so a stalled receiver holds the block with no loss
module genotype_pca_projection_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[1:0] allele_freq[17:2] weights_valid[18] component[23:19] weight[55:24]
    // sample[65:56] allele_a[69:66] allele_b[73:70] genotype_present[74], zero fill
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // value[47:0] status[49:48], zero fill
    output logic [55:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [5:0]   i_cfg_data
);
    import gpp_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SITE  = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_SCORE = 10'b0000010000,
        S_RD    = 10'b0000100000,
        S_MAC   = 10'b0001000000,
        S_WR    = 10'b0010000000,
        S_READ  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // input word fields
    logic [1:0]       in_cmd;
    logic [AF_W-1:0]  in_af;
    logic             in_wv;
    logic [4:0]       in_comp;
    logic [WGT_W-1:0] in_wgt;
    logic [9:0]       in_smp;
    logic [3:0]       in_a, in_b;
    logic             in_pres;

    assign in_cmd  = s_axis_tdata[1:0];
    assign in_af   = s_axis_tdata[17:2];
    assign in_wv   = s_axis_tdata[18];
    assign in_comp = s_axis_tdata[23:19];
    assign in_wgt  = s_axis_tdata[55:24];
    assign in_smp  = s_axis_tdata[65:56];
    assign in_a    = s_axis_tdata[69:66];
    assign in_b    = s_axis_tdata[73:70];
    assign in_pres = s_axis_tdata[74];

    t_state r_state;
    logic   r_homref;
    logic [NPC_W-1:0] r_npc;
    logic [AF_W-1:0]  r_freq;
    logic [INV_W-1:0] r_inv;
    logic             r_usable;

    // command word held while it works
    logic [PC_W-1:0]  r_comp;
    logic [SMP_W-1:0] r_smp;
    logic signed [18:0] r_d;       // centred dosage, Q.16
    logic signed [51:0] r_prod;    // d * inv_sd
    logic signed [31:0] r_score;
    logic [PC_W:0]    r_idx;       // component counter, holds MAX_PCS
    logic [PC_W:0]    r_nlim;
    logic signed [63:0] r_term;

    logic [ACC_W+1:0] r_out;       // status, value
    logic             r_ovalid;
    logic             r_prev_read;

    // memories
    logic signed [ACC_W-1:0] acc_mem [2**ACC_ADDR_W];
    logic signed [WGT_W-1:0] wgt_mem [MAX_PCS];
    logic [ACC_ADDR_W-1:0]   r_clr;
    logic                    acc_we;
    logic [ACC_ADDR_W-1:0]   acc_waddr, acc_raddr;
    logic signed [ACC_W-1:0] acc_wdata, r_acc_rd;
    logic signed [WGT_W-1:0] r_wgt_rd;

    t_sd_req sd_req;
    t_sd_rsp sd_rsp;

    gpp_inv_sd u_inv_sd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sd_req),
        .o_rsp   (sd_rsp)
    );

    logic in_acc;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign sd_req.start = in_acc && (in_cmd == CMD_SITE);
    assign sd_req.af = in_af;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'd0, r_out};

    // sample word decode
    logic [4:0] dose;
    logic signed [18:0] d_in;
    assign dose = {1'b0, in_a} + {1'b0, in_b};
    always_comb begin
        if (in_pres) d_in = $signed({1'b0, dose[1:0], 16'd0}) - $signed({2'b0, r_freq, 1'b0});
        else if (r_homref) d_in = -$signed({2'b0, r_freq, 1'b0});
        else d_in = '0;
    end

    // status of the incoming word; a sample word goes on to the sweep only when ok
    logic [1:0] in_st;
    always_comb begin
        in_st = ST_OK;
        case (in_cmd)
            CMD_SITE: begin
                if (!in_wv) in_st = ST_SKIP;
                else if (in_af == '0) in_st = ST_MONO;
            end
            CMD_SAMPLE: begin
                if (in_pres && dose > 5'd2) in_st = ST_DOSE;
                else if (!r_usable) in_st = ST_SKIP;
                else if (r_freq == '0) in_st = ST_MONO;
            end
            default: in_st = ST_OK;
        endcase
    end

    // saturation of the score and of the accumulator
    logic signed [51:0] sc_sh;
    logic signed [31:0] sc_sat;
    assign sc_sh = r_prod >>> 12;
    always_comb begin
        if (sc_sh > 52'sh7FFFFFFF) sc_sat = 32'sh7FFFFFFF;
        else if (sc_sh < -52'sh80000000) sc_sat = 32'sh80000000;
        else sc_sat = sc_sh[31:0];
    end

    // floor of term / 2^28, sign-extended to the sum width
    logic signed [35:0] term_sh;
    assign term_sh = r_term[63:28];

    logic signed [ACC_W:0] acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    assign acc_sum = {r_acc_rd[ACC_W-1], r_acc_rd} + {{(ACC_W-35){term_sh[35]}}, term_sh};
    always_comb begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_sat = acc_sum[ACC_W-1:0];
    end

    logic [PC_W-1:0] idx_lo;
    assign idx_lo = r_idx[PC_W-1:0];

    always_comb begin
        acc_we = 1'b0;
        acc_waddr = {r_smp, idx_lo};
        acc_wdata = acc_sat;
        acc_raddr = {r_smp, idx_lo};
        if (r_state == S_CLEAR) begin
            acc_we = 1'b1;
            acc_waddr = r_clr;
            acc_wdata = '0;
        end else if (r_state == S_WR) begin
            acc_we = 1'b1;
        end else if (r_state == S_READ) begin
            acc_raddr = {r_smp, r_comp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
        r_acc_rd <= acc_mem[acc_raddr];
        if (in_acc && in_cmd == CMD_WEIGHT) wgt_mem[in_comp] <= in_wgt;
        r_wgt_rd <= wgt_mem[idx_lo];
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_homref <= 1'b0;
            r_npc    <= NPC_W'(20);
            r_freq   <= '0;
            r_inv    <= '0;
            r_usable <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_HOMREF) r_homref <= i_cfg_data[0];
                else r_npc <= i_cfg_data;
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_comp <= in_comp;
                        r_smp <= in_smp;
                        r_out <= {in_st, {ACC_W{1'b0}}};
                        case (in_cmd)
                            CMD_SITE: begin
                                r_freq <= in_af;
                                r_usable <= in_wv;
                                r_state <= S_SITE;
                            end
                            CMD_WEIGHT: r_state <= S_OUT;
                            CMD_SAMPLE: begin
                                r_d <= d_in;
                                r_state <= (in_st == ST_OK) ? S_MUL : S_OUT;
                            end
                            default: r_state <= S_READ;
                        endcase
                    end
                end
                S_SITE: begin
                    if (sd_rsp.done) begin
                        r_inv <= sd_rsp.inv_sd;
                        r_state <= S_OUT;
                    end
                end
                S_MUL: begin
                    r_prod <= r_d * $signed({1'b0, r_inv});
                    r_idx <= '0;
                    r_nlim <= (r_npc > NPC_W'(MAX_PCS)) ? (PC_W+1)'(MAX_PCS)
                                                        : (PC_W+1)'(r_npc);
                    r_state <= S_SCORE;
                end
                S_SCORE: begin
                    r_score <= sc_sat;
                    r_state <= (r_nlim == '0) ? S_OUT : S_RD;
                end
                S_RD: r_state <= S_MAC;   // accumulator and weight read
                S_MAC: begin
                    r_term <= r_wgt_rd * r_score;
                    r_state <= S_WR;
                end
                S_WR: begin
                    // the next entry is a different address, so no forwarding is needed
                    r_idx <= r_idx + 1'b1;
                    r_state <= (r_idx + 1'b1 == r_nlim) ? S_OUT : S_RD;
                end
                S_READ: r_state <= S_OUT;
                S_OUT: begin
                    if (r_out[ACC_W+1:ACC_W] == ST_OK && r_prev_read)
                        r_out[ACC_W-1:0] <= r_acc_rd;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // read words land their memory data in the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_prev_read <= 1'b0;
        else if (in_acc) r_prev_read <= (in_cmd == CMD_READ);
    end

endmodule
